### rtl/crpt_pkg.sv
`default_nettype none

package crpt_pkg;

  localparam int PT_W   = 16;
  localparam int REG_W  = 3 * PT_W;
  localparam int T_W    = 17;
  localparam int POS_W  = 18;
  localparam int DIR_W  = 20;
  localparam int IDX_W  = 2;
  localparam int A_W    = 18;
  localparam int BC_W   = 21;
  localparam int DEPTH  = 8;

  localparam logic [IDX_W-1:0] REG_POINT_0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_POINT_1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_POINT_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_POINT_3 = 2'd3;

  typedef logic signed [PT_W-1:0] coord_t;

endpackage

`default_nettype wire

### rtl/crpt_coef.sv
`default_nettype none

module crpt_coef
  import crpt_pkg::*;
(
  input  wire logic             clk,
  input  wire coord_t           p0,
  input  wire coord_t           p1,
  input  wire coord_t           p2,
  input  wire coord_t           p3,
  output logic signed [A_W-1:0]  a,
  output logic signed [BC_W-1:0] b,
  output logic signed [BC_W-1:0] c
);

  logic signed [BC_W-1:0] e0, e1, e2, e3;
  logic signed [A_W-1:0]  f0, f2;

  assign e0 = BC_W'(p0);
  assign e1 = BC_W'(p1);
  assign e2 = BC_W'(p2);
  assign e3 = BC_W'(p3);
  assign f0 = A_W'(p0);
  assign f2 = A_W'(p2);

  // a = p2 - p0, b = 2p0 - 5p1 + 4p2 - p3, c = -p0 + 3p1 - 3p2 + p3
  always_ff @(posedge clk) begin
    a <= f2 - f0;
    b <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c <= e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
  end

endmodule

`default_nettype wire

### rtl/crpt_axis.sv
`default_nettype none

module crpt_axis
  import crpt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [T_W-1:0]         t_param,
  input  wire logic signed [A_W-1:0]  a,
  input  wire logic signed [BC_W-1:0] b,
  input  wire logic signed [BC_W-1:0] c,
  input  wire coord_t                 p1,
  output logic signed [POS_W-1:0]     pos,
  output logic signed [DIR_W-1:0]     dir
);

  localparam logic signed [25:0] POS_HI = 26'sd131071;
  localparam logic signed [25:0] POS_LO = -26'sd131072;
  localparam logic signed [24:0] DIR_HI = 25'sd524287;
  localparam logic signed [24:0] DIR_LO = -25'sd524288;

  // parameter delay line; u1, u3 and u5 feed the stages that multiply
  logic [T_W-1:0] u1, u2, u3, u4, u5;
  logic signed [T_W:0] us1, us3, us5;

  logic signed [38:0] m1;
  logic signed [39:0] h;
  logic signed [40:0] d;
  logic signed [41:0] hhu;
  logic [32:0]        hlu;
  logic signed [42:0] dhu;
  logic [32:0]        dlu;
  logic signed [55:0] s2;
  logic signed [57:0] m;
  logic signed [41:0] shu;
  logic [32:0]        smu, slu;
  logic signed [DIR_W-1:0] dir6, dir7;
  logic signed [24:0] praw;

  logic signed [23:0] hh;
  logic [15:0]        hl;
  logic signed [24:0] dh;
  logic [15:0]        dl;
  logic signed [23:0] sh;
  logic signed [73:0] psum;
  logic signed [24:0] mq;
  logic signed [25:0] pfull;

  assign us1 = $signed({1'b0, u1});
  assign us3 = $signed({1'b0, u3});
  assign us5 = $signed({1'b0, u5});

  assign hh = h[39:16];
  assign hl = h[15:0];
  assign dh = d[40:16];
  assign dl = d[15:0];
  assign sh = s2[55:32];

  assign psum = (74'(shu) <<< 32)
              + $signed({25'b0, smu, 16'b0})
              + $signed({41'b0, slu});
  assign mq = m[57:33];
  assign pfull = 26'(praw) + 26'(p1);

  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [24:0] v);
    logic signed [DIR_W-1:0] r;
    if (v > DIR_HI) begin
      r = DIR_HI[DIR_W-1:0];
    end else if (v < DIR_LO) begin
      r = DIR_LO[DIR_W-1:0];
    end else begin
      r = v[DIR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [25:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_HI) begin
      r = POS_HI[POS_W-1:0];
    end else if (v < POS_LO) begin
      r = POS_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    u1 <= t_param;
    u2 <= u1;
    u3 <= u2;
    u4 <= u3;
    u5 <= u4;

    // c*u
    m1 <= 39'(c) * 39'(us1);

    // c*u + b*2^16 and 3c*u + 2b*2^16
    h <= 40'(m1) + (40'(b) <<< 16);
    d <= (41'(m1) <<< 1) + 41'(m1) + (41'(b) <<< 17);

    // split products by u
    hhu <= 42'(hh) * 42'(us3);
    hlu <= 33'(hl) * 33'(u3);
    dhu <= 43'(dh) * 43'(us3);
    dlu <= 33'(dl) * 33'(u3);

    // s2 and derivative numerator
    s2 <= (56'(hhu) <<< 16) + $signed({23'b0, hlu}) + (56'(a) <<< 32);
    m  <= (58'(dhu) <<< 16) + $signed({25'b0, dlu}) + (58'(a) <<< 32);

    // s2*u in three slices, derivative rounded down and clamped
    shu  <= 42'(sh) * 42'(us5);
    smu  <= 33'(s2[31:16]) * 33'(u5);
    slu  <= 33'(s2[15:0]) * 33'(u5);
    dir6 <= sat_dir(mq);

    praw <= psum[73:49];
    dir7 <= dir6;

    pos <= sat_pos(pfull);
    dir <= dir7;
  end

endmodule

`default_nettype wire

### rtl/catmull_rom_point_and_tangent.sv
// channel   ports                                        handshake
// ------    -------------------------------------------  ------------------------
// input     t_param                                      start & !busy
// result    pos_x pos_y pos_z dir_x dir_y dir_z          done, one cycle, no stall
// config    cfg_index cfg_data                           cfg_valid & cfg_ready
//
// one word per cycle; each result passes through the eight-stage multiply
// chain per axis (c*u, adds, two split-product stages, sums)
// busy and cfg_ready hold off only during reset and the cycle after it
// reset clears the control points and the valid pipeline
// nothing in the pipeline ever waits: results leave on the done strobe
`default_nettype none

module catmull_rom_point_and_tangent
  import crpt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [T_W-1:0]         t_param,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [IDX_W-1:0]       cfg_index,
  input  wire logic [REG_W-1:0]       cfg_data,
  output logic                        done,
  output logic signed [POS_W-1:0]     pos_x,
  output logic signed [POS_W-1:0]     pos_y,
  output logic signed [POS_W-1:0]     pos_z,
  output logic signed [DIR_W-1:0]     dir_x,
  output logic signed [DIR_W-1:0]     dir_y,
  output logic signed [DIR_W-1:0]     dir_z
);

  logic [REG_W-1:0] point [4];
  logic [DEPTH-1:0] vld;
  logic             accept;

  logic signed [POS_W-1:0] pos_v [3];
  logic signed [DIR_W-1:0] dir_v [3];

  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;
  assign done      = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      for (int i = 0; i < 4; i++) begin
        point[i] <= '0;
      end
    end else begin
      busy <= 1'b0;
      vld  <= {vld[DEPTH-2:0], accept};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POINT_0: point[0] <= cfg_data;
          REG_POINT_1: point[1] <= cfg_data;
          REG_POINT_2: point[2] <= cfg_data;
          REG_POINT_3: point[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [A_W-1:0]  a;
    logic signed [BC_W-1:0] b;
    logic signed [BC_W-1:0] c;

    crpt_coef u_coef (
      .clk (clk),
      .p0  (coord_t'(point[0][PT_W*ax +: PT_W])),
      .p1  (coord_t'(point[1][PT_W*ax +: PT_W])),
      .p2  (coord_t'(point[2][PT_W*ax +: PT_W])),
      .p3  (coord_t'(point[3][PT_W*ax +: PT_W])),
      .a   (a),
      .b   (b),
      .c   (c)
    );

    crpt_axis u_axis (
      .clk     (clk),
      .t_param (t_param),
      .a       (a),
      .b       (b),
      .c       (c),
      .p1      (coord_t'(point[1][PT_W*ax +: PT_W])),
      .pos     (pos_v[ax]),
      .dir     (dir_v[ax])
    );
  end

  assign pos_x = pos_v[0];
  assign pos_y = pos_v[1];
  assign pos_z = pos_v[2];
  assign dir_x = dir_v[0];
  assign dir_y = dir_v[1];
  assign dir_z = dir_v[2];

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  import crpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TWO16   = 64'sd65536;
  localparam longint TWO32   = 64'sd4294967296;
  localparam longint POS_HI  = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_LO  = -(64'sd1 <<< (POS_W - 1));
  localparam longint DIR_HI  = (64'sd1 <<< (DIR_W - 1)) - 1;
  localparam longint DIR_LO  = -(64'sd1 <<< (DIR_W - 1));
  localparam int     QUIET_LIMIT = 1000;
  localparam int     PHASE_WORDS = 333;

  localparam logic [IDX_W-1:0] PT_REG [4] = '{REG_POINT_0, REG_POINT_1,
                                              REG_POINT_2, REG_POINT_3};

  localparam logic [REG_W-1:0] ALL_MAX = {3{16'h7FFF}};
  localparam logic [REG_W-1:0] ALL_MIN = {3{16'h8000}};

  typedef logic [3:0][REG_W-1:0] point_set_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][DIR_W-1:0] dir;
  } curve_sample_t;

  typedef struct {
    point_set_t      pts;
    logic [T_W-1:0]  t;
    bit              fixed;
    longint          pos_v;
    longint          dir_v;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [T_W-1:0]          t_param;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [REG_W-1:0]        cfg_data;
  logic                    done;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;

  point_set_t      ctrl_pts;
  curve_sample_t   pending_samples[$];
  stim_row_t       dir_table[$];
  int              idle_pct;
  int              n_err;
  int              n_sent;
  int              n_checked;
  int              n_cfg;
  int              n_sets;
  int              n_sat;
  int              quiet_cycles;

  catmull_rom_point_and_tangent u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .t_param   (t_param),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic curve_sample_t eval_segment(point_set_t pts, logic [T_W-1:0] t);
    curve_sample_t r;
    longint p [4];
    longint u, a, b, c, s2, s2h, s2l, num, m, pv, dv;
    u = longint'(t);
    for (int axis = 0; axis < 3; axis++) begin
      for (int k = 0; k < 4; k++) begin
        p[k] = longint'($signed(pts[k][axis*PT_W +: PT_W]));
      end
      a = p[2] - p[0];
      b = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
      c = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
      // split the cubic term so the product stays inside 64 bits
      s2  = (c * u + b * TWO16) * u + a * TWO32;
      s2h = s2 >>> 16;
      s2l = s2 - s2h * TWO16;
      num = s2h * u + 2 * p[1] * TWO32 + ((s2l * u) >>> 16);
      pv  = num >>> 33;
      if (pv > POS_HI) pv = POS_HI;
      if (pv < POS_LO) pv = POS_LO;
      m  = (3 * c * u + 2 * b * TWO16) * u + a * TWO32;
      dv = m >>> 33;
      if (dv > DIR_HI) dv = DIR_HI;
      if (dv < DIR_LO) dv = DIR_LO;
      r.pos[axis] = pv[POS_W-1:0];
      r.dir[axis] = dv[DIR_W-1:0];
    end
    return r;
  endfunction

  function automatic stim_row_t row(point_set_t pts, logic [T_W-1:0] t, bit fixed,
                                    longint pv, longint dv);
    stim_row_t r;
    r.pts   = pts;
    r.t     = t;
    r.fixed = fixed;
    r.pos_v = pv;
    r.dir_v = dv;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] rand_point();
    logic [REG_W-1:0] v;
    for (int axis = 0; axis < 3; axis++) begin
      case ($urandom_range(7))
        0: v[axis*PT_W +: PT_W] = 16'h7FFF;
        1: v[axis*PT_W +: PT_W] = 16'h8000;
        2: v[axis*PT_W +: PT_W] = 16'h0000;
        3: v[axis*PT_W +: PT_W] = 16'hFFFF;
        4: v[axis*PT_W +: PT_W] = 16'($signed(11'($urandom_range(2047))));
        default: v[axis*PT_W +: PT_W] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic point_set_t rand_set();
    point_set_t s;
    case ($urandom_range(11))
      0: s = {4{ALL_MAX}};
      1: s = {4{ALL_MIN}};
      2: s = {ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX};
      3: s = {ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN};
      default: s = {rand_point(), rand_point(), rand_point(), rand_point()};
    endcase
    return s;
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(9))
      0: return '0;
      1: return T_W'(65536);
      2: return T_W'($urandom_range(65537, 131071));
      3: return T_W'(131071);
      default: return T_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch %0d: %s expected %0d, got %0d", n_err, what, want, got);
    end
  endtask

  task automatic write_point(int slot, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= PT_REG[slot];
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    ctrl_pts[slot] = val;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_points(point_set_t np);
    for (int slot = 0; slot < 4; slot++) begin
      if (np[slot] !== ctrl_pts[slot]) write_point(slot, np[slot]);
    end
    n_sets++;
  endtask

  task automatic flush_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(logic [T_W-1:0] t, bit fixed, longint pv, longint dv);
    curve_sample_t e;
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    t_param <= t;
    do @(posedge clk); while (busy);
    if (fixed) begin
      for (int axis = 0; axis < 3; axis++) begin
        e.pos[axis] = pv[POS_W-1:0];
        e.dir[axis] = dv[DIR_W-1:0];
      end
    end else begin
      e = eval_segment(ctrl_pts, t);
    end
    pending_samples.push_back(e);
    n_sent++;
  endtask

  always @(posedge clk) begin : check_results
    curve_sample_t         e;
    logic [2:0][POS_W-1:0] got_pos;
    logic [2:0][DIR_W-1:0] got_dir;
    string                 axis_name [3];
    longint                ep, ed;
    axis_name = '{"x", "y", "z"};
    if (!rst && done) begin
      got_pos = {pos_z, pos_y, pos_x};
      got_dir = {dir_z, dir_y, dir_x};
      if (pending_samples.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("mismatch %0d: result word with nothing expected", n_err);
      end else begin
        e = pending_samples.pop_front();
        n_checked++;
        for (int axis = 0; axis < 3; axis++) begin
          if (got_pos[axis] !== e.pos[axis]) begin
            note_mismatch({"pos_", axis_name[axis]}, longint'($signed(e.pos[axis])),
                          longint'($signed(got_pos[axis])));
          end
          if (got_dir[axis] !== e.dir[axis]) begin
            note_mismatch({"dir_", axis_name[axis]}, longint'($signed(e.dir[axis])),
                          longint'($signed(got_dir[axis])));
          end
          ep = longint'($signed(e.pos[axis]));
          ed = longint'($signed(e.dir[axis]));
          if (ep == POS_HI || ep == POS_LO || ed == DIR_HI || ed == DIR_LO) begin
            n_sat++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("catmull_rom_point_and_tangent test failed");
        $finish;
      end
    end
  end

  initial begin
    point_set_t mix_a, mix_b, alt_hi, alt_lo;
    int         in_phase;
    int         grp;

    rst          = 1'b1;
    start        = 1'b0;
    t_param      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_POINT_0;
    cfg_data     = '0;
    ctrl_pts     = '0;
    idle_pct     = 0;
    n_err        = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_cfg        = 0;
    n_sets       = 0;
    n_sat        = 0;
    quiet_cycles = 0;

    // p0 = +max, p1 = -max alternating: large t drives every axis to the low rail
    alt_lo = {ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX};
    alt_hi = {ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN};
    mix_a  = {{16'h7FFF, 16'h8000, 16'h1234}, {16'h0200, 16'h0001, 16'hFFFF},
              {16'hFF80, 16'h0120, 16'h0000}, {16'h0300, 16'hFD00, 16'h0040}};
    // tiny values around zero exercise rounding toward minus infinity
    mix_b  = {{16'hFFFD, 16'h0000, 16'h0003}, {16'h0001, 16'h0002, 16'hFFFE},
              {16'h0000, 16'hFFFF, 16'h0001}, {16'hFFFF, 16'h0001, 16'hFFFF}};

    // registers after reset are all zero
    dir_table.push_back(row('0, T_W'(0), 1, 0, 0));
    dir_table.push_back(row('0, T_W'(65536), 1, 0, 0));
    dir_table.push_back(row('0, T_W'(131071), 1, 0, 0));
    // constant curve: position equals the point, tangent is zero
    dir_table.push_back(row({4{ALL_MAX}}, T_W'(0), 1, 32767, 0));
    dir_table.push_back(row({4{ALL_MAX}}, T_W'(131071), 1, 32767, 0));
    dir_table.push_back(row({4{ALL_MIN}}, T_W'(0), 1, -32768, 0));
    dir_table.push_back(row({4{ALL_MIN}}, T_W'(65536), 1, -32768, 0));
    // extrapolation past the segment end saturates both outputs; later rows use eval_segment
    dir_table.push_back(row(alt_lo, T_W'(131071), 1, POS_LO, DIR_LO));
    dir_table.push_back(row(alt_hi, T_W'(131071), 1, POS_HI, DIR_HI));
    dir_table.push_back(row(alt_hi, T_W'(32768), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(0), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(1), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(32768), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(65535), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(65536), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(65537), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(100000), 0, 0, 0));
    dir_table.push_back(row(mix_a, T_W'(131071), 0, 0, 0));
    dir_table.push_back(row(mix_b, T_W'(17'h15555), 0, 0, 0));
    dir_table.push_back(row(mix_b, T_W'(17'h0AAAA), 0, 0, 0));
    dir_table.push_back(row(mix_b, T_W'(3), 0, 0, 0));
    dir_table.push_back(row(mix_b, T_W'(65533), 0, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].pts !== ctrl_pts) begin
        flush_pipe();
        load_points(dir_table[i].pts);
      end
      send_sample(dir_table[i].t, dir_table[i].fixed, dir_table[i].pos_v,
                  dir_table[i].dir_v);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 34 : (phase == 1) ? 47 : 0;
      in_phase = 0;
      while (in_phase < PHASE_WORDS) begin
        flush_pipe();
        load_points(rand_set());
        grp = $urandom_range(20, 60);
        repeat (grp) send_sample(rand_t(), 0, 0, 0);
        in_phase += grp;
      end
    end

    flush_pipe();
    repeat (12) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $display("%0d expected result words never arrived", pending_samples.size());
      n_err += pending_samples.size();
    end

    $display("sent %0d samples over %0d point sets with %0d register writes",
             n_sent, n_sets, n_cfg);
    $display("checked %0d result words, %0d axes hit a saturation rail, %0d errors",
             n_checked, n_sat, n_err);
    if (n_err == 0) begin
      $display("catmull_rom_point_and_tangent test passed");
    end else begin
      $display("catmull_rom_point_and_tangent test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/crpt_pkg.sv
rtl/crpt_coef.sv
rtl/crpt_axis.sv
rtl/catmull_rom_point_and_tangent.sv
tb/sv/testbench.sv
